[rtl/core/c8ic_pkg.sv]
// Shared types, constants and opcode names for the CHIP-8 instruction core.
// No dependencies; the ALU and the top level of the core import this package.
package c8ic_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int SCREEN_W = 64;
    localparam int SCREEN_H = 32;
    localparam int STACK_DEPTH = 16;

    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int SCR_XW = $clog2(SCREEN_W);
    localparam int SCR_YW = $clog2(SCREEN_H);
    localparam int FB_AW = SCR_XW + SCR_YW;
    localparam int PIX_COUNT = SCREEN_W * SCREEN_H;
    localparam int SP_W = $clog2(STACK_DEPTH);

    localparam logic [11:0] PROG_START_RST = 12'd512;
    localparam logic [11:0] FONT_BASE_RST = 12'd80;
    localparam logic [7:0] TIMER_RST = 8'd255;

    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_EXEC = 3'd1,
        ACT_TICK = 3'd2,
        ACT_RDPIX = 3'd3,
        ACT_RDMEM = 3'd4
    } t_action;

    localparam logic CFG_PROG_START = 1'b0;
    localparam logic CFG_FONT_BASE = 1'b1;

    localparam logic [3:0] OPG_SYS = 4'h0;
    localparam logic [3:0] OPG_JP = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SE = 4'h3;
    localparam logic [3:0] OPG_SNE = 4'h4;
    localparam logic [3:0] OPG_SER = 4'h5;
    localparam logic [3:0] OPG_LD = 4'h6;
    localparam logic [3:0] OPG_ADD = 4'h7;
    localparam logic [3:0] OPG_ALU = 4'h8;
    localparam logic [3:0] OPG_SNER = 4'h9;
    localparam logic [3:0] OPG_LDI = 4'hA;
    localparam logic [3:0] OPG_JPV = 4'hB;
    localparam logic [3:0] OPG_RND = 4'hC;
    localparam logic [3:0] OPG_DRW = 4'hD;
    localparam logic [3:0] OPG_KEY = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    localparam logic [3:0] AN_MOV = 4'h0;
    localparam logic [3:0] AN_OR = 4'h1;
    localparam logic [3:0] AN_AND = 4'h2;
    localparam logic [3:0] AN_XOR = 4'h3;
    localparam logic [3:0] AN_ADD = 4'h4;
    localparam logic [3:0] AN_SUB = 4'h5;
    localparam logic [3:0] AN_SHR = 4'h6;
    localparam logic [3:0] AN_SUBN = 4'h7;
    localparam logic [3:0] AN_SHL = 4'hE;

    localparam logic [7:0] NN_CLS = 8'hE0;
    localparam logic [7:0] NN_RET = 8'hEE;
    localparam logic [7:0] NN_SKP = 8'h9E;
    localparam logic [7:0] NN_SKNP = 8'hA1;
    localparam logic [7:0] NN_LDDT = 8'h07;
    localparam logic [7:0] NN_SETDT = 8'h15;
    localparam logic [7:0] NN_SETST = 8'h18;
    localparam logic [7:0] NN_ADDI = 8'h1E;
    localparam logic [7:0] NN_FONT = 8'h29;
    localparam logic [7:0] NN_BCD = 8'h33;
    localparam logic [7:0] NN_STORE = 8'h55;
    localparam logic [7:0] NN_LOAD = 8'h65;

    localparam logic [7:0] BCD_HUNDRED = 8'd100;
    localparam logic [7:0] BCD_TEN = 8'd10;

    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD,
        ALU_SUB,
        ALU_SHR,
        ALU_SHL
    } t_alu_op;

    typedef struct packed {
        logic [7:0] res;
        logic flag;
        logic ge;
        logic eq;
    } t_alu_res;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RDPIX, ST_RDMEM,
        ST_F0, ST_F1, ST_F2, ST_RX, ST_RY, ST_R0, ST_EX, ST_WF,
        ST_CLS, ST_DR0, ST_DR1, ST_DR2, ST_DR3,
        ST_B1, ST_B2, ST_B3, ST_B4, ST_B5,
        ST_ST, ST_LD0, ST_LD1, ST_DONE
    } t_state;

endpackage

[rtl/core/c8ic_ram.sv]
// Generic single-port RAM with a registered read port.
// Depends on nothing; used for main memory and the framebuffer.
module c8ic_ram #(
    parameter int W = 8,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/c8ic_alu.sv]
// Shared 8-bit arithmetic, logic, shift and compare unit.
// Depends on c8ic_pkg for the operation and result types.
module c8ic_alu (
    input  c8ic_pkg::t_alu_op  i_op,
    input  logic [7:0]         i_a,
    input  logic [7:0]         i_b,
    output c8ic_pkg::t_alu_res o_res
);
    import c8ic_pkg::*;

    logic [8:0] sum;
    logic [8:0] diff;

    assign sum = {1'b0, i_a} + {1'b0, i_b};
    assign diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        o_res.ge = !diff[8];
        o_res.eq = (i_a == i_b);
        o_res.flag = 1'b0;
        unique case (i_op)
            ALU_PASS: o_res.res = i_b;
            ALU_OR: o_res.res = i_a | i_b;
            ALU_AND: o_res.res = i_a & i_b;
            ALU_XOR: o_res.res = i_a ^ i_b;
            ALU_ADD: begin
                o_res.res = sum[7:0];
                o_res.flag = sum[8];
            end
            ALU_SUB: begin
                o_res.res = diff[7:0];
                o_res.flag = !diff[8] && (i_a != i_b);
            end
            ALU_SHR: begin
                o_res.res = {1'b0, i_a[7:1]};
                o_res.flag = i_a[0];
            end
            ALU_SHL: begin
                o_res.res = {i_a[6:0], 1'b0};
                o_res.flag = i_a[7];
            end
            default: o_res.res = i_b;
        endcase
    end
endmodule

[rtl/core/chip8_instruction_core.sv]
// Top level of the CHIP-8 instruction core: sequencer, register file, stack, timers.
// Depends on c8ic_pkg, c8ic_ram and c8ic_alu.
//
// Usage: present an action with its fields and raise start while busy is low; the
// request is taken at that clock edge. Exactly one result follows, shown for one
// cycle with o_valid high; the receiver cannot hold it off. Configuration writes
// (program start, font base) use i_cfg_we, i_cfg_index and i_cfg_data and take
// effect at once; the program start is only loaded into the PC by reset.
// Sequence: memory write and timer tick go straight to the result, reads through a read
// state first. An instruction runs through fetch, register reads and execute, plus: a
// flag write, the hundreds and tens digit loops for BCD, a step per register for store
// and a read and a write step per register for load, a pass over the framebuffer for a
// screen clear, and for a sprite draw a row read plus a step per column and per set
// pixel, all from the single memory port and the shared ALU being stepped by the
// sequencer. One request is handled at a time. After reset, busy stays high while main
// memory and the framebuffer are cleared one entry per cycle.
module chip8_instruction_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [11:0]             i_cfg_data,
    input  logic [2:0]              i_action,
    input  logic [11:0]             i_address,
    input  logic [7:0]              i_write_data,
    input  logic [15:0]             i_key_state,
    input  logic [7:0]              i_random_byte,
    output logic                    o_valid,
    output logic [7:0]              o_read_data,
    output logic [11:0]             o_program_counter,
    output logic [15:0]             o_index_value,
    output logic [7:0]              o_delay_value,
    output logic                    o_sound_on
);
    import c8ic_pkg::*;

    t_state r_state, n_state;

    logic [11:0] r_prog_start, r_font_base;
    logic [11:0] r_pc;
    logic [15:0] r_index;
    logic [7:0] r_dt, r_st;
    logic [7:0] r_v [16];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [SP_W-1:0] r_sp;

    logic [11:0] r_addr;
    logic [15:0] r_keys;
    logic [7:0] r_rnd;
    logic [7:0] r_rdata;
    logic [15:0] r_op;
    logic [7:0] r_vx, r_vy, r_v0;
    logic r_flag;
    logic [MEM_AW-1:0] r_cnt;
    logic [3:0] r_row, r_col, r_i;
    logic [7:0] r_sprite, r_t;
    logic [3:0] r_bh, r_bt;
    logic r_hit;

    logic mem_we;
    logic [MEM_AW-1:0] mem_a;
    logic [7:0] mem_d, mem_q;
    logic fb_we;
    logic [FB_AW-1:0] fb_a;
    logic fb_d, fb_q;
    logic [3:0] v_raddr;
    logic [7:0] v_rd;
    logic rf_we;
    logic [3:0] rf_wa;
    logic [7:0] rf_wd;
    t_alu_op alu_op;
    logic [7:0] alu_a, alu_b;
    t_alu_res alu_out;

    logic [3:0] op_g, op_x, op_y, op_n;
    logic [7:0] op_nn;
    logic [11:0] op_nnn;
    logic [7:0] pix_x, pix_y;
    logic [FB_AW-1:0] pix_idx;
    logic accept;
    logic alu_8xy_flag;

    assign op_g = r_op[15:12];
    assign op_x = r_op[11:8];
    assign op_y = r_op[7:4];
    assign op_n = r_op[3:0];
    assign op_nn = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign pix_x = r_vx + {4'd0, r_col};
    assign pix_y = r_vy + {4'd0, r_row};
    assign pix_idx = {pix_y[SCR_YW-1:0], pix_x[SCR_XW-1:0]};
    assign v_rd = r_v[v_raddr];
    assign accept = start && !busy;
    assign alu_8xy_flag = (op_n == AN_ADD) || (op_n == AN_SUB) || (op_n == AN_SHR) ||
                          (op_n == AN_SUBN) || (op_n == AN_SHL);

    c8ic_ram #(.W(8), .AW(MEM_AW)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_a), .i_wdata(mem_d), .o_rdata(mem_q)
    );

    c8ic_ram #(.W(1), .AW(FB_AW)) u_fb (
        .i_clk(i_clk), .i_we(fb_we), .i_addr(fb_a), .i_wdata(fb_d), .o_rdata(fb_q)
    );

    c8ic_alu u_alu (.i_op(alu_op), .i_a(alu_a), .i_b(alu_b), .o_res(alu_out));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_cnt == {MEM_AW{1'b1}}) n_state = ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    case (i_action)
                        ACT_EXEC: n_state = ST_F0;
                        ACT_RDPIX: n_state = ST_RDPIX;
                        ACT_RDMEM: n_state = ST_RDMEM;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_RDPIX, ST_RDMEM, ST_WF, ST_B5: n_state = ST_DONE;
            ST_F0: n_state = ST_F1;
            ST_F1: n_state = ST_F2;
            ST_F2: n_state = ST_RX;
            ST_RX: n_state = ST_RY;
            ST_RY: n_state = ST_R0;
            ST_R0: n_state = ST_EX;
            ST_EX: begin
                n_state = ST_DONE;
                case (op_g)
                    OPG_SYS: if (op_nn == NN_CLS) n_state = ST_CLS;
                    OPG_ALU: if (alu_8xy_flag) n_state = ST_WF;
                    OPG_DRW: n_state = ST_DR0;
                    OPG_MISC: begin
                        if (op_nn == NN_BCD) n_state = ST_B1;
                        else if (op_nn == NN_STORE) n_state = ST_ST;
                        else if (op_nn == NN_LOAD) n_state = ST_LD0;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_CLS: if (r_cnt[FB_AW-1:0] == {FB_AW{1'b1}}) n_state = ST_DONE;
            ST_DR0: n_state = (r_row == op_n) ? ST_DONE : ST_DR1;
            ST_DR1: n_state = ST_DR2;
            ST_DR2: begin
                if (r_col == 4'd8) n_state = ST_DR0;
                else if (r_sprite[7]) n_state = ST_DR3;
            end
            ST_DR3: n_state = ST_DR2;
            ST_B1: if (!alu_out.ge) n_state = ST_B2;
            ST_B2: if (!alu_out.ge) n_state = ST_B3;
            ST_B3: n_state = ST_B4;
            ST_B4: n_state = ST_B5;
            ST_ST: if (r_i == op_x) n_state = ST_DONE;
            ST_LD0: n_state = ST_LD1;
            ST_LD1: n_state = (r_i == op_x) ? ST_DONE : ST_LD0;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_a = r_pc[MEM_AW-1:0];
        mem_d = 8'd0;
        fb_we = 1'b0;
        fb_a = pix_idx;
        fb_d = 1'b0;
        v_raddr = r_i;
        rf_we = 1'b0;
        rf_wa = op_x;
        rf_wd = alu_out.res;
        alu_op = ALU_SUB;
        alu_a = r_vx;
        alu_b = r_vy;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_a = r_cnt;
                fb_we = 1'b1;
                fb_a = r_cnt[FB_AW-1:0];
            end
            ST_IDLE: begin
                mem_a = i_address[MEM_AW-1:0];
                mem_d = i_write_data;
                mem_we = start && (i_action == ACT_WRITE);
                fb_a = i_address[FB_AW-1:0];
            end
            ST_F1: mem_a = r_pc[MEM_AW-1:0] + MEM_AW'(1);
            ST_RX: v_raddr = op_x;
            ST_RY: v_raddr = op_y;
            ST_R0: v_raddr = 4'd0;
            ST_EX: begin
                case (op_g)
                    OPG_SE, OPG_SNE: alu_b = op_nn;
                    OPG_LD: begin
                        rf_we = 1'b1;
                        rf_wd = op_nn;
                    end
                    OPG_ADD: begin
                        alu_op = ALU_ADD;
                        alu_b = op_nn;
                        rf_we = 1'b1;
                    end
                    OPG_ALU: begin
                        rf_we = 1'b1;
                        case (op_n)
                            AN_MOV: alu_op = ALU_PASS;
                            AN_OR: alu_op = ALU_OR;
                            AN_AND: alu_op = ALU_AND;
                            AN_XOR: alu_op = ALU_XOR;
                            AN_ADD: alu_op = ALU_ADD;
                            AN_SUB: alu_op = ALU_SUB;
                            AN_SHR: alu_op = ALU_SHR;
                            AN_SUBN: begin
                                alu_a = r_vy;
                                alu_b = r_vx;
                            end
                            AN_SHL: alu_op = ALU_SHL;
                            default: rf_we = 1'b0;
                        endcase
                    end
                    OPG_RND: begin
                        rf_we = 1'b1;
                        rf_wd = r_rnd & op_nn;
                    end
                    OPG_MISC: begin
                        if (op_nn == NN_LDDT) begin
                            rf_we = 1'b1;
                            rf_wd = r_dt;
                        end
                    end
                    default: rf_we = 1'b0;
                endcase
            end
            ST_WF: begin
                rf_we = 1'b1;
                rf_wa = 4'hF;
                rf_wd = {7'd0, r_flag};
            end
            ST_CLS: begin
                fb_we = 1'b1;
                fb_a = r_cnt[FB_AW-1:0];
            end
            ST_DR0: begin
                mem_a = r_index[MEM_AW-1:0] + MEM_AW'(r_row);
                rf_we = (r_row == op_n);
                rf_wa = 4'hF;
                rf_wd = {7'd0, r_hit};
            end
            ST_DR3: begin
                fb_we = 1'b1;
                fb_d = !fb_q;
            end
            ST_B1: begin
                alu_a = r_t;
                alu_b = BCD_HUNDRED;
            end
            ST_B2: begin
                alu_a = r_t;
                alu_b = BCD_TEN;
            end
            ST_B3: begin
                mem_we = 1'b1;
                mem_a = r_index[MEM_AW-1:0];
                mem_d = {4'd0, r_bh};
            end
            ST_B4: begin
                mem_we = 1'b1;
                mem_a = r_index[MEM_AW-1:0] + MEM_AW'(1);
                mem_d = {4'd0, r_bt};
            end
            ST_B5: begin
                mem_we = 1'b1;
                mem_a = r_index[MEM_AW-1:0] + MEM_AW'(2);
                mem_d = r_t;
            end
            ST_ST: begin
                mem_we = 1'b1;
                mem_a = r_index[MEM_AW-1:0] + MEM_AW'(r_i);
                mem_d = v_rd;
            end
            ST_LD0: mem_a = r_index[MEM_AW-1:0] + MEM_AW'(r_i);
            ST_LD1: begin
                rf_we = 1'b1;
                rf_wa = r_i;
                rf_wd = mem_q;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_start <= PROG_START_RST;
            r_font_base <= FONT_BASE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PROG_START) r_prog_start <= i_cfg_data;
            else r_font_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
        end else if (rf_we) begin
            r_v[rf_wa] <= rf_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt <= '0;
            r_pc <= r_prog_start;
            r_index <= 16'd0;
            r_dt <= TIMER_RST;
            r_st <= TIMER_RST;
            r_sp <= '0;
            for (int k = 0; k < STACK_DEPTH; k++) r_stack[k] <= 12'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR || r_state == ST_CLS) r_cnt <= r_cnt + MEM_AW'(1);
            if (accept) begin
                r_addr <= i_address;
                r_keys <= i_key_state;
                r_rnd <= i_random_byte;
                r_rdata <= 8'd0;
                if (i_action == ACT_TICK) begin
                    if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                    if (r_st != 8'd0) r_st <= r_st - 8'd1;
                end
            end
            unique case (r_state)
                ST_RDPIX: r_rdata <= (int'(r_addr) < PIX_COUNT) ? {7'd0, fb_q} : 8'd0;
                ST_RDMEM: r_rdata <= mem_q;
                ST_F1: r_op[15:8] <= mem_q;
                ST_F2: r_op[7:0] <= mem_q;
                ST_RX: begin
                    r_vx <= v_rd;
                    r_pc <= r_pc + 12'd2;
                end
                ST_RY: r_vy <= v_rd;
                ST_R0: r_v0 <= v_rd;
                ST_EX: begin
                    r_flag <= alu_out.flag;
                    r_cnt <= '0;
                    r_row <= 4'd0;
                    r_hit <= 1'b0;
                    r_i <= 4'd0;
                    r_t <= r_vx;
                    r_bh <= 4'd0;
                    r_bt <= 4'd0;
                    case (op_g)
                        OPG_SYS: begin
                            if (op_nn == NN_RET) begin
                                r_pc <= r_stack[r_sp];
                                r_sp <= r_sp - SP_W'(1);
                            end
                        end
                        OPG_JP: r_pc <= op_nnn;
                        OPG_CALL: begin
                            r_stack[r_sp + SP_W'(1)] <= r_pc;
                            r_sp <= r_sp + SP_W'(1);
                            r_pc <= op_nnn;
                        end
                        OPG_SE, OPG_SER: if (alu_out.eq) r_pc <= r_pc + 12'd2;
                        OPG_SNE, OPG_SNER: if (!alu_out.eq) r_pc <= r_pc + 12'd2;
                        OPG_LDI: r_index <= {4'd0, op_nnn};
                        OPG_JPV: r_pc <= op_nnn + {4'd0, r_v0};
                        OPG_KEY: begin
                            if ((op_nn == NN_SKP && r_keys[r_vx[3:0]]) ||
                                (op_nn == NN_SKNP && !r_keys[r_vx[3:0]]))
                                r_pc <= r_pc + 12'd2;
                        end
                        OPG_MISC: begin
                            case (op_nn)
                                NN_SETDT: r_dt <= r_vx;
                                NN_SETST: r_st <= r_vx;
                                NN_ADDI: r_index <= r_index + {8'd0, r_vx};
                                NN_FONT: r_index <= {4'd0, r_font_base} +
                                    {10'd0, r_vx[3:0], 2'd0} + {12'd0, r_vx[3:0]};
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                ST_DR1: begin
                    r_sprite <= mem_q;
                    r_col <= 4'd0;
                end
                ST_DR2: begin
                    if (r_col == 4'd8) begin
                        r_row <= r_row + 4'd1;
                    end else if (!r_sprite[7]) begin
                        r_col <= r_col + 4'd1;
                        r_sprite <= {r_sprite[6:0], 1'b0};
                    end
                end
                ST_DR3: begin
                    r_hit <= r_hit | fb_q;
                    r_col <= r_col + 4'd1;
                    r_sprite <= {r_sprite[6:0], 1'b0};
                end
                ST_B1: begin
                    if (alu_out.ge) begin
                        r_t <= alu_out.res;
                        r_bh <= r_bh + 4'd1;
                    end
                end
                ST_B2: begin
                    if (alu_out.ge) begin
                        r_t <= alu_out.res;
                        r_bt <= r_bt + 4'd1;
                    end
                end
                ST_ST: r_i <= r_i + 4'd1;
                ST_LD1: r_i <= r_i + 4'd1;
                default: r_flag <= r_flag;
            endcase
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_read_data = r_rdata;
    assign o_program_counter = r_pc;
    assign o_index_value = r_index;
    assign o_delay_value = r_dt;
    assign o_sound_on = (r_st != 8'd0);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("core not busy after a request");
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_pix_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DR3) |-> ($past(r_state) == ST_DR2))
        else $error("pixel write without preceding read");
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_valid) else $error("result during clearing pass");
endmodule

[test/chip8_checker.sv]
// Checker for the CHIP-8 instruction core: watches requests, config writes and results,
// predicts each result with its own interpreter state and compares field by field.
// Depends on c8ic_pkg.
module chip8_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_key_state,
    input  logic [7:0]  i_random_byte,
    input  logic        o_valid,
    input  logic [7:0]  o_read_data,
    input  logic [11:0] o_program_counter,
    input  logic [15:0] o_index_value,
    input  logic [7:0]  o_delay_value,
    input  logic        o_sound_on,
    output int          fail_count
);
    import c8ic_pkg::*;

    typedef struct {
        logic [7:0]  rd;
        logic [11:0] pc;
        logic [15:0] idx;
        logic [7:0]  dt;
        logic        snd;
    } t_core_view;

    logic [7:0]  mem [MEM_BYTES];
    logic        pix [PIX_COUNT];
    logic [7:0]  v [16];
    logic [11:0] stk [16];
    logic [3:0]  sp;
    logic [11:0] pc;
    logic [15:0] ireg;
    logic [7:0]  dtim;
    logic [7:0]  stim;
    logic [11:0] prog_start;
    logic [11:0] font_base;

    t_core_view view_q[$];
    int mismatches;

    function automatic logic [11:0] maddr(input logic [15:0] a);
        return a[11:0];
    endfunction

    task automatic run_opcode(input logic [15:0] keys, input logic [7:0] rnd);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, row;
        logic [8:0]  wide;
        logic        hit;
        logic [5:0]  xx;
        logic [4:0]  yy;
        op = {mem[pc], mem[pc + 12'd1]};
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        vx = v[x];
        vy = v[y];
        pc = pc + 12'd2;
        case (op[15:12])
            OPG_SYS: begin
                if (nn == NN_CLS) begin
                    foreach (pix[k]) pix[k] = 1'b0;
                end else if (nn == NN_RET) begin
                    pc = stk[sp];
                    sp = sp - 4'd1;
                end
            end
            OPG_JP: pc = op[11:0];
            OPG_CALL: begin
                sp = sp + 4'd1;
                stk[sp] = pc;
                pc = op[11:0];
            end
            OPG_SE: if (vx == nn) pc = pc + 12'd2;
            OPG_SNE: if (vx != nn) pc = pc + 12'd2;
            OPG_SER: if (vx == vy) pc = pc + 12'd2;
            OPG_LD: v[x] = nn;
            OPG_ADD: v[x] = vx + nn;
            OPG_ALU: begin
                case (n)
                    AN_MOV: v[x] = vy;
                    AN_OR: v[x] = vx | vy;
                    AN_AND: v[x] = vx & vy;
                    AN_XOR: v[x] = vx ^ vy;
                    AN_ADD: begin
                        wide = vx + vy;
                        v[x] = wide[7:0];
                        v[15] = {7'd0, wide[8]};
                    end
                    AN_SUB: begin
                        v[x] = vx - vy;
                        v[15] = {7'd0, vx > vy};
                    end
                    AN_SHR: begin
                        v[x] = vx >> 1;
                        v[15] = {7'd0, vx[0]};
                    end
                    AN_SUBN: begin
                        v[x] = vy - vx;
                        v[15] = {7'd0, vy > vx};
                    end
                    AN_SHL: begin
                        v[x] = vx << 1;
                        v[15] = {7'd0, vx[7]};
                    end
                    default: ;
                endcase
            end
            OPG_SNER: if (vx != vy) pc = pc + 12'd2;
            OPG_LDI: ireg = {4'd0, op[11:0]};
            OPG_JPV: pc = op[11:0] + {4'd0, v[0]};
            OPG_RND: v[x] = rnd & nn;
            OPG_DRW: begin
                hit = 1'b0;
                for (int r = 0; r < n; r++) begin
                    row = mem[maddr(ireg + r)];
                    yy = vy[4:0] + r[4:0];
                    for (int c = 0; c < 8; c++) begin
                        xx = vx[5:0] + c[5:0];
                        if (row[7 - c]) begin
                            if (pix[{yy, xx}]) hit = 1'b1;
                            pix[{yy, xx}] = !pix[{yy, xx}];
                        end
                    end
                end
                v[15] = {7'd0, hit};
            end
            OPG_KEY: begin
                if ((nn == NN_SKP && keys[vx[3:0]]) || (nn == NN_SKNP && !keys[vx[3:0]]))
                    pc = pc + 12'd2;
            end
            default: begin
                case (nn)
                    NN_LDDT: v[x] = dtim;
                    NN_SETDT: dtim = vx;
                    NN_SETST: stim = vx;
                    NN_ADDI: ireg = ireg + vx;
                    NN_FONT: ireg = {4'd0, font_base} + 16'd5 * vx[3:0];
                    NN_BCD: begin
                        mem[maddr(ireg)] = vx / BCD_HUNDRED;
                        mem[maddr(ireg + 16'd1)] = (vx / BCD_TEN) % BCD_TEN;
                        mem[maddr(ireg + 16'd2)] = vx % BCD_TEN;
                    end
                    NN_STORE: for (int i = 0; i <= x; i++) mem[maddr(ireg + i)] = v[i];
                    NN_LOAD: for (int i = 0; i <= x; i++) v[i] = mem[maddr(ireg + i)];
                    default: ;
                endcase
            end
        endcase
    endtask

    task automatic apply_request(output t_core_view res);
        logic [7:0] rd;
        rd = 8'd0;
        case (i_action)
            ACT_WRITE: mem[i_address] = i_write_data;
            ACT_EXEC: run_opcode(i_key_state, i_random_byte);
            ACT_TICK: begin
                if (dtim != 8'd0) dtim = dtim - 8'd1;
                if (stim != 8'd0) stim = stim - 8'd1;
            end
            ACT_RDPIX: if (i_address < PIX_COUNT) rd = {7'd0, pix[i_address[10:0]]};
            ACT_RDMEM: rd = mem[i_address];
            default: ;
        endcase
        res.rd = rd;
        res.pc = pc;
        res.idx = ireg;
        res.dt = dtim;
        res.snd = stim != 8'd0;
    endtask

    always @(posedge i_clk) begin
        t_core_view want;
        t_core_view got;
        if (!i_rst_n) begin
            foreach (mem[k]) mem[k] = 8'd0;
            foreach (pix[k]) pix[k] = 1'b0;
            foreach (v[k]) v[k] = 8'd0;
            foreach (stk[k]) stk[k] = 12'd0;
            sp = 4'd0;
            prog_start = PROG_START_RST;
            font_base = FONT_BASE_RST;
            pc = prog_start;
            ireg = 16'd0;
            dtim = TIMER_RST;
            stim = TIMER_RST;
            view_q.delete();
            mismatches = 0;
        end else begin
            if (o_valid) begin
                if (view_q.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = view_q.pop_front();
                    got = '{o_read_data, o_program_counter, o_index_value, o_delay_value,
                            o_sound_on};
                    if (got.rd !== want.rd) begin
                        $error("read_data: expected %0h, actual %0h", want.rd, got.rd);
                        mismatches++;
                    end
                    if (got.pc !== want.pc) begin
                        $error("program_counter: expected %0h, actual %0h", want.pc, got.pc);
                        mismatches++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("index_value: expected %0h, actual %0h", want.idx, got.idx);
                        mismatches++;
                    end
                    if (got.dt !== want.dt) begin
                        $error("delay_value: expected %0h, actual %0h", want.dt, got.dt);
                        mismatches++;
                    end
                    if (got.snd !== want.snd) begin
                        $error("sound_on: expected %0h, actual %0h", want.snd, got.snd);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PROG_START) prog_start = i_cfg_data;
                else font_base = i_cfg_data;
            end
            if (start && !busy) begin
                apply_request(want);
                view_q.push_back(want);
            end
        end
        fail_count <= mismatches + view_q.size();
    end

endmodule

[test/tb.sv]
// Testbench top for the CHIP-8 instruction core: reset, config writes, directed and
// random requests with idle gaps, and the final verdict.
// Depends on c8ic_pkg, chip8_instruction_core and chip8_checker.
module tb;
    import c8ic_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_PROG_START;
    logic [11:0] i_cfg_data = 12'd0;
    logic [2:0]  i_action = ACT_TICK;
    logic [11:0] i_address = 12'd0;
    logic [7:0]  i_write_data = 8'd0;
    logic [15:0] i_key_state = 16'd0;
    logic [7:0]  i_random_byte = 8'd0;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic [11:0] o_program_counter;
    logic [15:0] o_index_value;
    logic [7:0]  o_delay_value;
    logic        o_sound_on;
    int          fail_count;

    int          sent_cnt = 0;
    int          done_cnt = 0;
    logic [11:0] last_pc = PROG_START_RST;
    logic        quiet = 1'b0;

    chip8_instruction_core u_top (.*);
    chip8_checker u_chk (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (o_valid) begin
            done_cnt <= done_cnt + 1;
            last_pc <= o_program_counter;
        end
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input t_action act, input logic [11:0] addr,
                                input logic [7:0] data);
        if (!quiet && $urandom_range(0, 99) < 29) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_address <= addr;
        i_write_data <= data;
        i_key_state <= 16'($urandom);
        i_random_byte <= 8'($urandom);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sent_cnt++;
    endtask

    task automatic drain;
        start <= 1'b0;
        wait (done_cnt == sent_cnt);
        @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [11:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_opcode(input logic [15:0] op);
        drain();
        send_request(ACT_WRITE, last_pc, op[15:8]);
        send_request(ACT_WRITE, last_pc + 12'd1, op[7:0]);
        send_request(ACT_EXEC, 12'($urandom), 8'($urandom));
    endtask

    function automatic logic [15:0] pick_opcode;
        logic [15:0] r;
        int w;
        r = 16'($urandom);
        w = $urandom_range(0, 99);
        if (w < 2) return {OPG_SYS, 4'h0, NN_CLS};
        if (w < 6) return {OPG_SYS, 4'h0, NN_RET};
        if (w < 8) return {OPG_SYS, r[11:0]};
        if (w < 10) return {OPG_JP, r[11:0]};
        if (w < 13) return {OPG_CALL, r[11:0]};
        if (w < 20) return {r[0] ? OPG_SE : OPG_SNE, r[11:0]};
        if (w < 23) return {r[15] ? OPG_SER : OPG_SNER, r[11:0]};
        if (w < 33) return {OPG_LD, r[11:0]};
        if (w < 38) return {OPG_ADD, r[11:0]};
        if (w < 52) return {OPG_ALU, r[11:0]};
        if (w < 56) return {OPG_LDI, r[11:0]};
        if (w < 58) return {OPG_JPV, r[11:0]};
        if (w < 62) return {OPG_RND, r[11:0]};
        if (w < 71) return {OPG_DRW, r[11:0]};
        if (w < 76) return {OPG_KEY, r[11:8], r[12] ? NN_SKP : (r[13] ? NN_SKNP : r[7:0])};
        case ($urandom_range(0, 9))
            0: return {OPG_MISC, r[11:8], NN_LDDT};
            1: return {OPG_MISC, r[11:8], NN_SETDT};
            2: return {OPG_MISC, r[11:8], NN_SETST};
            3: return {OPG_MISC, r[11:8], NN_ADDI};
            4: return {OPG_MISC, r[11:8], NN_FONT};
            5: return {OPG_MISC, r[11:8], NN_BCD};
            6: return {OPG_MISC, r[11:8], NN_STORE};
            7: return {OPG_MISC, r[11:8], NN_LOAD};
            default: return {OPG_MISC, r[11:0]};
        endcase
    endfunction

    initial begin
        logic [11:0] a;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (!busy);
        @(posedge i_clk);
        write_cfg(CFG_FONT_BASE, 12'hFFF);
        write_cfg(CFG_PROG_START, 12'h000);

        send_request(ACT_WRITE, 12'hFFF, 8'hFF);
        send_request(ACT_WRITE, 12'h000, 8'h80);
        send_request(ACT_RDMEM, 12'hFFF, 8'h00);
        send_request(ACT_RDMEM, 12'h000, 8'h00);
        send_request(ACT_RDPIX, 12'd2047, 8'h00);
        send_request(ACT_RDPIX, 12'hFFF, 8'h00);
        send_request(ACT_TICK, 12'h000, 8'h00);
        run_opcode({OPG_LD, 4'hE, 8'hFF});
        run_opcode({OPG_ALU, 4'hE, 4'hE, AN_ADD});
        run_opcode({OPG_LDI, 12'hFFF});
        run_opcode({OPG_DRW, 4'hE, 4'hD, 4'h2});
        run_opcode({OPG_DRW, 4'hE, 4'hD, 4'h2});
        run_opcode({OPG_MISC, 4'hE, NN_BCD});
        send_request(ACT_RDPIX, 12'd62, 8'h00);
        send_request(ACT_RDPIX, 12'd64, 8'h00);

        while (sent_cnt < 480) begin
            quiet = sent_cnt >= 180 && sent_cnt < 280;
            if (sent_cnt >= 300 && sent_cnt < 304) begin
                write_cfg(CFG_FONT_BASE, 12'h000);
                write_cfg(CFG_PROG_START, 12'hFFF);
            end else if (sent_cnt >= 400 && sent_cnt < 404) begin
                write_cfg(CFG_FONT_BASE, 12'($urandom));
            end
            if ($urandom_range(0, 99) < 70) begin
                run_opcode(pick_opcode());
            end else begin
                a = 12'($urandom);
                case ($urandom_range(0, 4))
                    0: send_request(ACT_WRITE, a, 8'($urandom));
                    1: send_request(ACT_EXEC, a, 8'($urandom));
                    2: send_request(ACT_TICK, a, 8'($urandom));
                    3: send_request(ACT_RDPIX, $urandom_range(0, 3) != 0 ? {1'b0, a[10:0]} : a,
                                    8'($urandom));
                    default: send_request(ACT_RDMEM, a, 8'($urandom));
                endcase
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
